FILE: hw/rtl/ita2_pkg.sv
// Types, constants and code tables of the ITA2 / ASCII shift codec.
// Used by every other file of the block; depends on nothing.
package ita2_pkg;

  localparam int CharW  = 8;
  localparam int AsciiW = 7;
  localparam int CodeW  = 5;
  localparam int OutW   = 7;
  localparam int NCodes = 32;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [0:0] RegDirIdx = 1'b0;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  localparam logic [CodeW-1:0] CodeFigs = 5'h1B;
  localparam logic [CodeW-1:0] CodeLtrs = 5'h1F;

  localparam logic [AsciiW-1:0] LowerA    = 7'h61;
  localparam logic [AsciiW-1:0] LowerZ    = 7'h7A;
  localparam logic [AsciiW-1:0] CaseDelta = 7'h20;
  localparam logic [AsciiW-1:0] AsciiQuot = 7'h22;
  localparam logic [AsciiW-1:0] AsciiApos = 7'h27;

  localparam logic [AsciiW-1:0] LtrsTab [NCodes] = '{
    7'h00, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49, 7'h55,
    7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43, 7'h4B,
    7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50, 7'h51,
    7'h4F, 7'h42, 7'h47, 7'h00, 7'h4D, 7'h58, 7'h56, 7'h00
  };

  localparam logic [AsciiW-1:0] FigsTab [NCodes] = '{
    7'h00, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h27, 7'h38, 7'h37,
    7'h0D, 7'h05, 7'h34, 7'h07, 7'h2C, 7'h21, 7'h3A, 7'h28,
    7'h35, 7'h2B, 7'h29, 7'h32, 7'h24, 7'h36, 7'h30, 7'h31,
    7'h39, 7'h3F, 7'h26, 7'h00, 7'h2E, 7'h2F, 7'h3B, 7'h00
  };

  typedef struct packed {
    logic             hit_l;
    logic             hit_f;
    logic [CodeW-1:0] code_l;
    logic [CodeW-1:0] code_f;
  } enc_t;

  typedef struct packed {
    logic [OutW-1:0] out_code;
    logic            last;
  } word_t;

  typedef struct packed {
    logic  vld;
    word_t word;
  } emit_t;

  // Reverse lookup: first code in each shift whose character matches.
  function automatic enc_t enc_lookup(input logic [AsciiW-1:0] a);
    enc_t r;
    r = '0;
    for (int i = 0; i < NCodes; i++) begin
      if (CodeW'(i) != CodeFigs && CodeW'(i) != CodeLtrs) begin
        if (!r.hit_l && LtrsTab[i] == a) begin
          r.hit_l  = 1'b1;
          r.code_l = CodeW'(i);
        end
        if (!r.hit_f && FigsTab[i] == a) begin
          r.hit_f  = 1'b1;
          r.code_f = CodeW'(i);
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ita2_if.sv
// Valid/ready channel interfaces for input characters and output words.
// Depends on ita2_pkg for the payload widths.
interface ita2_char_if;
  logic                         valid;
  logic                         ready;
  logic [ita2_pkg::CharW-1:0]   in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface ita2_code_if;
  logic                         valid;
  logic                         ready;
  logic [ita2_pkg::OutW-1:0]    out_code;
  logic                         last;

  modport source (output valid, output out_code, output last, input ready);
  modport sink   (input valid, input out_code, input last, output ready);
endinterface

FILE: hw/rtl/ita2_apb_regs.sv
// APB register file of the codec: the direction register.
// Depends on ita2_pkg.
module ita2_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ita2_pkg::ApbAddrW-1:0] paddr,
  input  logic [ita2_pkg::ApbDataW-1:0] pwdata,
  output logic [ita2_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic                          direction_o
);

  logic       direction_q;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ita2_pkg::ApbAddrW-1:ita2_pkg::ApbAddrW-1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == ita2_pkg::RegDirIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= ita2_pkg::DirEncode;
    end else if (wr_en) begin
      direction_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == ita2_pkg::RegDirIdx) begin
      prdata[0] = direction_q;
    end
  end

  assign direction_o = direction_q;

endmodule

FILE: hw/rtl/ita2_xlate.sv
// Input register, shift state and translation logic of the codec.
// Emits one word per cycle while out_free_i is set. Depends on ita2_pkg, ita2_if.
module ita2_xlate (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  direction_i,
  ita2_char_if.sink             in_i,
  input  logic                  out_free_i,
  output ita2_pkg::emit_t       emit_o
);

  logic                              in_vld_q;
  logic [ita2_pkg::CharW-1:0]        char_q;
  logic                              figs_q;
  logic                              figs_d;
  logic [ita2_pkg::AsciiW-1:0]       a;
  logic [ita2_pkg::CodeW-1:0]        c;
  ita2_pkg::enc_t                    enc;
  ita2_pkg::emit_t                   emit;
  logic                              done;
  logic                              step;
  logic                              pop;

  always_comb begin
    a = char_q[ita2_pkg::AsciiW-1:0];
    if (a inside {[ita2_pkg::LowerA:ita2_pkg::LowerZ]}) begin
      a = a - ita2_pkg::CaseDelta;
    end
    if (a == ita2_pkg::AsciiQuot) begin
      a = ita2_pkg::AsciiApos;
    end
    enc = ita2_pkg::enc_lookup(a);
    c   = char_q[ita2_pkg::CodeW-1:0];

    emit           = '0;
    emit.word.last = 1'b1;
    done           = 1'b0;
    figs_d         = figs_q;

    if (in_vld_q) begin
      if (direction_i == ita2_pkg::DirEncode) begin
        if (enc.hit_l && enc.hit_f && enc.code_l == enc.code_f) begin
          emit.vld           = 1'b1;
          emit.word.out_code = ita2_pkg::OutW'(enc.code_l);
          done               = 1'b1;
        end else if (enc.hit_l) begin
          emit.vld = 1'b1;
          if (figs_q) begin
            // send LTRS first, keep the character until its letter code is sent
            emit.word.out_code = ita2_pkg::OutW'(ita2_pkg::CodeLtrs);
            emit.word.last     = 1'b0;
            figs_d             = 1'b0;
          end else begin
            emit.word.out_code = ita2_pkg::OutW'(enc.code_l);
            done               = 1'b1;
          end
        end else if (enc.hit_f) begin
          emit.vld = 1'b1;
          if (!figs_q) begin
            emit.word.out_code = ita2_pkg::OutW'(ita2_pkg::CodeFigs);
            emit.word.last     = 1'b0;
            figs_d             = 1'b1;
          end else begin
            emit.word.out_code = ita2_pkg::OutW'(enc.code_f);
            done               = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end else begin
        done = 1'b1;
        if (c == ita2_pkg::CodeFigs) begin
          figs_d = 1'b1;
        end else if (c == ita2_pkg::CodeLtrs) begin
          figs_d = 1'b0;
        end else begin
          emit.vld           = 1'b1;
          emit.word.out_code = figs_q ? ita2_pkg::FigsTab[c] : ita2_pkg::LtrsTab[c];
        end
      end
    end
  end

  assign step     = in_vld_q && (!emit.vld || out_free_i);
  assign pop      = step && done;
  assign in_i.ready = !in_vld_q || pop;

  assign emit_o.vld  = emit.vld && step;
  assign emit_o.word = emit.word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      figs_q   <= 1'b0;
    end else begin
      if (step) begin
        figs_q <= figs_d;
      end
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (pop) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.in_char;
    end
  end

endmodule

FILE: hw/rtl/ita2_out_reg.sv
// Output word register of the codec; holds a word while the receiver stalls.
// Depends on ita2_pkg, ita2_if.
module ita2_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ita2_pkg::emit_t emit_i,
  output logic            free_o,
  ita2_code_if.source     out_o
);

  logic            vld_q;
  ita2_pkg::word_t word_q;

  assign free_o = !vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= emit_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && emit_i.vld) begin
      word_q <= emit_i.word;
    end
  end

  assign out_o.valid    = vld_q;
  assign out_o.out_code = word_q.out_code;
  assign out_o.last     = word_q.last;

endmodule

FILE: hw/rtl/ita2_ascii_shift_codec.sv
// ITA2 / ASCII shift codec, top level.
// Depends on ita2_pkg, ita2_if, ita2_apb_regs, ita2_xlate, ita2_out_reg.
//
// Usage:
//   in_i takes one character word per valid/ready handshake; out_o gives
//   result words, each with out_code and last (last marks the final word
//   of one input character). direction (APB register 0, bit 0) selects
//   encode (0, ASCII to ITA2) or decode (1, ITA2 to ASCII); write it only
//   while the block is idle.
//   Path: an accepted character is held in the input register and its word
//   is registered in the output register, the character word behind a
//   FIGS or LTRS code after that code. Throughput: one output word per
//   cycle while the receiver takes them, set by the single output register;
//   a shifted character holds the translation stage for both its words.
//   Characters with no code, and shift codes when decoding, give no word.
//   Reset: shift state returns to letters, direction to encode, both
//   pipeline stages empty.
//   Receiver stall: the output register holds its word and the translation
//   stage holds its character; in_i ready stays low while that character
//   still has a word to give.
module ita2_ascii_shift_codec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ita2_char_if.sink                     in_i,
  ita2_code_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ita2_pkg::ApbAddrW-1:0] paddr,
  input  logic [ita2_pkg::ApbDataW-1:0] pwdata,
  output logic [ita2_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  logic            direction;
  logic            out_free;
  ita2_pkg::emit_t emit;

  ita2_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .direction_o (direction)
  );

  ita2_xlate u_xlate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction),
    .in_i        (in_i),
    .out_free_i  (out_free),
    .emit_o      (emit)
  );

  ita2_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
